// ----- hw/rtl/mme_pkg.sv -----
// Shared types, codes and helpers of the matrix multiply engine.
package mme_pkg;

  localparam int unsigned DIM_W = 4;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned ACC_W = 32;
  localparam int unsigned VAL_W = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD_LEFT  = 2'd0,
    FUNC_LOAD_RIGHT = 2'd1,
    FUNC_COMPUTE    = 2'd2,
    FUNC_NONE       = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_INNER = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  // Control of one ring cell: shift advances the ring, clr starts a fresh sum.
  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] d;
    d = v;
    if (d == '0) d = DIM_W'(1);
    if (d > max_dim) d = max_dim;
    return d;
  endfunction

endpackage

// ----- hw/rtl/mme_store.sv -----
// Element store: one write port, one registered read port.
module mme_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 6
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic signed [WIDTH-1:0] rdata_o
);

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic signed [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mme_cell.sv -----
// One accumulator cell of the rotating partial-sum ring.
module mme_cell (
  input  logic                            clk_i,
  input  mme_pkg::cell_ctl_t              ctl_i,
  input  logic [mme_pkg::ACC_W-1:0]       acc_i,
  input  logic [mme_pkg::ACC_W-1:0]       add_i,
  output logic [mme_pkg::ACC_W-1:0]       acc_o,
  output logic [mme_pkg::ACC_W-1:0]       sum_o
);

  logic [mme_pkg::ACC_W-1:0] acc_q, acc_d;

  // Take the neighbor's sum (or zero to start) and add this cycle's term.
  assign acc_d = (ctl_i.clr ? '0 : acc_i) + add_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) acc_q <= acc_d;
  end

  assign acc_o = acc_q;
  assign sum_o = acc_d;

endmodule

// ----- hw/rtl/matrix_multiply_engine.sv -----
// Top level of the integer matrix multiply engine.
// Load transactions (func 0 / 1) write one element of the left or right matrix
// at a row-major index; indexes beyond the store are dropped. A compute
// transaction (func 2) emits rows*cols results in row-major order, the last one
// flagged. The engine walks r, then k, then c, issuing one left/right read pair
// per cycle while the output is not stalled; after a read stage and a multiply
// stage the product enters a ring of MAX_DIM accumulator cells that rotates one
// step per product, so the partial sum of column c comes back to the head
// exactly cols steps later. Output stall freezes the whole pipeline. Input is
// stalled while a compute is in flight. Configuration writes are always
// accepted and take effect at once.
module matrix_multiply_engine #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        func_i,
  input  logic [5:0]                        index_i,
  input  logic signed [mme_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mme_pkg::ACC_W-1:0]  result_o,
  output logic [mme_pkg::IDX_W-1:0]         row_idx_o,
  output logic [mme_pkg::IDX_W-1:0]         col_idx_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [mme_pkg::DIM_W-1:0]         cfg_data_i
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [mme_pkg::DIM_W-1:0] MaxDim = mme_pkg::DIM_W'(MAX_DIM);

  typedef struct packed {
    logic          clr;
    logic          emit;
    logic          last;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
  } tag_t;

  // Configuration registers, held clamped.
  logic [mme_pkg::DIM_W-1:0] rows_q, cols_q, inner_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= MaxDim;
      cols_q  <= MaxDim;
      inner_q <= MaxDim;
    end else if (cfg_valid_i) begin
      unique case (mme_pkg::reg_idx_e'(cfg_index_i))
        mme_pkg::REG_ROWS:  rows_q  <= mme_pkg::clamp_dim(cfg_data_i, MaxDim);
        mme_pkg::REG_COLS:  cols_q  <= mme_pkg::clamp_dim(cfg_data_i, MaxDim);
        mme_pkg::REG_INNER: inner_q <= mme_pkg::clamp_dim(cfg_data_i, MaxDim);
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic          run_q, v1_q, v2_q, out_valid_q;
  logic [IW-1:0] r_q, k_q, c_q;
  tag_t          tag1_q, tag2_q;
  logic          adv, in_acc, last_c, last_k, last_r;

  // Freeze the pipeline while a finished result waits at the output.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = run_q || v1_q || v2_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign last_c = (mme_pkg::DIM_W'(c_q) == cols_q - 1'b1);
  assign last_k = (mme_pkg::DIM_W'(k_q) == inner_q - 1'b1);
  assign last_r = (mme_pkg::DIM_W'(r_q) == rows_q - 1'b1);

  // Load path: keep the low ELEM_WIDTH bits of the sign-extended value.
  logic                         in_range, we_left, we_right;
  logic signed [ELEM_WIDTH-1:0] elem;

  assign in_range = ({26'b0, index_i} < 32'(DEPTH));
  assign elem     = ELEM_WIDTH'(value_i);
  assign we_left  = in_acc && in_range
                    && (mme_pkg::func_e'(func_i) == mme_pkg::FUNC_LOAD_LEFT);
  assign we_right = in_acc && in_range
                    && (mme_pkg::func_e'(func_i) == mme_pkg::FUNC_LOAD_RIGHT);

  // Read addresses: left[r*inner + k], right[k*cols + c].
  logic [7:0]                   laddr, raddr;
  logic signed [ELEM_WIDTH-1:0] a_rd, b_rd;

  assign laddr = 8'(r_q) * 8'(inner_q) + 8'(k_q);
  assign raddr = 8'(k_q) * 8'(cols_q) + 8'(c_q);

  mme_store #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH), .AW(AW)) u_left (
    .clk_i   (clk_i),
    .we_i    (we_left),
    .waddr_i (AW'(index_i)),
    .wdata_i (elem),
    .re_i    (adv),
    .raddr_i (AW'(laddr)),
    .rdata_o (a_rd)
  );

  mme_store #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH), .AW(AW)) u_right (
    .clk_i   (clk_i),
    .we_i    (we_right),
    .waddr_i (AW'(index_i)),
    .wdata_i (elem),
    .re_i    (adv),
    .raddr_i (AW'(raddr)),
    .rdata_o (b_rd)
  );

  // Issue stage: walk rows, then inner terms, then columns.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      r_q   <= '0;
      k_q   <= '0;
      c_q   <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (in_acc && (mme_pkg::func_e'(func_i) == mme_pkg::FUNC_COMPUTE)) begin
        run_q <= 1'b1;
        r_q   <= '0;
        k_q   <= '0;
        c_q   <= '0;
      end else if (run_q && adv) begin
        if (!last_c) begin
          c_q <= c_q + 1'b1;
        end else begin
          c_q <= '0;
          if (!last_k) begin
            k_q <= k_q + 1'b1;
          end else begin
            k_q <= '0;
            if (!last_r) r_q <= r_q + 1'b1;
            else         run_q <= 1'b0;
          end
        end
      end
      if (adv) begin
        v1_q <= run_q;
        v2_q <= v1_q;
      end
    end
  end

  logic signed [2*ELEM_WIDTH-1:0] prod_full;
  logic [mme_pkg::ACC_W-1:0]      prod_q;

  assign prod_full = a_rd * b_rd;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag1_q.clr  <= (k_q == '0);
      tag1_q.emit <= last_k;
      tag1_q.last <= last_k && last_r && last_c;
      tag1_q.row  <= r_q;
      tag1_q.col  <= c_q;
      tag2_q      <= tag1_q;
      prod_q      <= mme_pkg::ACC_W'(prod_full);
    end
  end

  // Accumulator ring: cell 0 adds the product, the rest hand sums along.
  logic [mme_pkg::ACC_W-1:0] ring   [MAX_DIM];
  logic [mme_pkg::ACC_W-1:0] sums   [MAX_DIM];
  logic [mme_pkg::DIM_W-1:0] tap;
  logic                      step;

  assign step = adv && v2_q;
  assign tap  = cols_q - 1'b1;

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_ring
    mme_pkg::cell_ctl_t        ctl;
    logic [mme_pkg::ACC_W-1:0] acc_in, add_in;
    if (i == 0) begin : g_head
      assign ctl.shift = step;
      assign ctl.clr   = tag2_q.clr;
      assign acc_in    = ring[tap[IW-1:0]];
      assign add_in    = prod_q;
    end else begin : g_body
      assign ctl.shift = step;
      assign ctl.clr   = 1'b0;
      assign acc_in    = ring[i-1];
      assign add_in    = '0;
    end
    mme_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .acc_i (acc_in),
      .add_i (add_in),
      .acc_o (ring[i]),
      .sum_o (sums[i])
    );
  end

  // Output register: capture the head's finished sum.
  logic [mme_pkg::ACC_W-1:0] result_q;
  tag_t                      otag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q && tag2_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && tag2_q.emit) begin
      result_q <= sums[0];
      otag_q   <= tag2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign row_idx_o   = mme_pkg::IDX_W'(otag_q.row);
  assign col_idx_o   = mme_pkg::IDX_W'(otag_q.col);
  assign last_o      = otag_q.last;

  // A compute transaction starts the walk.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func_i == mme_pkg::FUNC_COMPUTE)) |=> run_q)
    else $error("compute did not start");

  // Loop counters stay inside the configured dimensions while running.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> ((mme_pkg::DIM_W'(r_q) < rows_q) && (mme_pkg::DIM_W'(k_q) < inner_q)
               && (mme_pkg::DIM_W'(c_q) < cols_q)))
    else $error("loop counter out of range");

  // A product waiting on a stalled output is held.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !adv) |=> (v2_q && $stable(prod_q)))
    else $error("product lost under stall");

endmodule

// ----- test/matrix_multiply_engine_tb.sv -----
// Self-checking testbench for the integer matrix multiply engine.
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;

  localparam int unsigned DIM_MAX      = 8;
  localparam int unsigned STORE_DEPTH  = DIM_MAX * DIM_MAX;
  localparam int unsigned WATCHDOG_MAX = 5000;
  localparam int unsigned SETTLE_CYC   = 10;
  localparam int unsigned HOLD_CYC     = 300;

  // One product element as seen on the result channel.
  typedef struct {
    logic signed [mme_pkg::ACC_W-1:0] sum;
    logic [mme_pkg::IDX_W-1:0]        row;
    logic [mme_pkg::IDX_W-1:0]        col;
    logic                             last;
  } product_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic [1:0]                       func_i;
  logic [5:0]                       index_i;
  logic signed [mme_pkg::VAL_W-1:0] value_i;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic signed [mme_pkg::ACC_W-1:0] result_o;
  logic [mme_pkg::IDX_W-1:0]        row_idx_o;
  logic [mme_pkg::IDX_W-1:0]        col_idx_o;
  logic                             last_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [1:0]                       cfg_index_i;
  logic [mme_pkg::DIM_W-1:0]        cfg_data_i;

  matrix_multiply_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .row_idx_o   (row_idx_o),
    .col_idx_o   (col_idx_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor state: our own copy of both operand stores and the dimensions.
  logic signed [mme_pkg::VAL_W-1:0] left_mat  [STORE_DEPTH];
  logic signed [mme_pkg::VAL_W-1:0] right_mat [STORE_DEPTH];
  bit                               left_set  [STORE_DEPTH];
  bit                               right_set [STORE_DEPTH];
  int unsigned                      n_rows, n_cols, n_inner;

  product_t    pending_products[$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_reqs   = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned n_items, n_computes;
  int unsigned n_products  = 0;
  int unsigned n_errors    = 0;
  int unsigned idle_cycles = 0;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic int unsigned dim_of(logic [mme_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  // Expand one compute transaction into its row-major list of products.
  function automatic void predict_products();
    product_t p;
    logic signed [mme_pkg::ACC_W-1:0] acc;
    for (int unsigned r = 0; r < n_rows; r++) begin
      for (int unsigned c = 0; c < n_cols; c++) begin
        acc = '0;
        for (int unsigned k = 0; k < n_inner; k++) begin
          acc += mme_pkg::ACC_W'(int'(left_mat[(r * n_inner + k) % STORE_DEPTH])
                 * int'(right_mat[(k * n_cols + c) % STORE_DEPTH]));
        end
        p.sum  = acc;
        p.row  = mme_pkg::IDX_W'(r);
        p.col  = mme_pkg::IDX_W'(c);
        p.last = (r == n_rows - 1) && (c == n_cols - 1);
        pending_products.push_back(p);
      end
    end
  endfunction

  // Offer one transaction, hold it until accepted, then update the predictor.
  task automatic send_item(mme_pkg::func_e f, logic [5:0] idx,
                           logic signed [mme_pkg::VAL_W-1:0] v);
    func_i     <= f;
    index_i    <= idx;
    value_i    <= v;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_items++;
    case (f)
      mme_pkg::FUNC_LOAD_LEFT: begin
        left_mat[idx] = v;
        left_set[idx] = 1'b1;
      end
      mme_pkg::FUNC_LOAD_RIGHT: begin
        right_mat[idx] = v;
        right_set[idx] = 1'b1;
      end
      mme_pkg::FUNC_COMPUTE: begin
        predict_products();
        n_computes++;
      end
      default: ;
    endcase
    // Drop valid for a random gap now and then.
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every product has come out, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_products.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write one register while the engine is idle.
  task automatic write_reg(mme_pkg::reg_idx_e ri, logic [mme_pkg::DIM_W-1:0] d);
    drain();
    cfg_index_i <= ri;
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (ri)
      mme_pkg::REG_ROWS:  n_rows  = dim_of(d);
      mme_pkg::REG_COLS:  n_cols  = dim_of(d);
      mme_pkg::REG_INNER: n_inner = dim_of(d);
      default: ;
    endcase
  endtask

  task automatic set_dims(logic [mme_pkg::DIM_W-1:0] r, logic [mme_pkg::DIM_W-1:0] c,
                          logic [mme_pkg::DIM_W-1:0] k);
    write_reg(mme_pkg::REG_ROWS, r);
    write_reg(mme_pkg::REG_COLS, c);
    write_reg(mme_pkg::REG_INNER, k);
  endtask

  function automatic logic signed [mme_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      default: return mme_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Load every operand the next compute reads that has never been written.
  // With refresh set, rewrite them all with fresh random content.
  task automatic load_operands(bit refresh);
    int unsigned i;
    for (int unsigned r = 0; r < n_rows; r++) begin
      for (int unsigned k = 0; k < n_inner; k++) begin
        i = (r * n_inner + k) % STORE_DEPTH;
        if (refresh || !left_set[i])
          send_item(mme_pkg::FUNC_LOAD_LEFT, 6'(i), rand_value());
      end
    end
    for (int unsigned k = 0; k < n_inner; k++) begin
      for (int unsigned c = 0; c < n_cols; c++) begin
        i = (k * n_cols + c) % STORE_DEPTH;
        if (refresh || !right_set[i])
          send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'(i), rand_value());
      end
    end
  endtask

  // Directed shapes: degenerate and clamped dimensions, extreme operands,
  // the unused function code, an unknown register index and the top index.
  task automatic test_directed_shapes();
    set_dims(4'd0, 4'd15, 4'd1);               // zero acts as one, 15 acts as eight
    send_item(mme_pkg::FUNC_LOAD_LEFT, 6'd0, 16'sh8000);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd0, 16'sh8000);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd1, 16'sh7fff);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd2, 16'sd0);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd3, -16'sd1);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd4, 16'sd1);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd5, 16'sh5555);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd6, 16'shaaaa);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd7, 16'sh7fff);
    send_item(mme_pkg::FUNC_NONE, 6'd63, 16'sh7fff);     // must give no product
    send_item(mme_pkg::FUNC_COMPUTE, 6'd0, 16'sd0);
    write_reg(mme_pkg::REG_NONE, 4'd15);                 // ignored register
    set_dims(4'd2, 4'd1, 4'd2);
    send_item(mme_pkg::FUNC_LOAD_LEFT, 6'd1, 16'sh7fff);
    send_item(mme_pkg::FUNC_LOAD_LEFT, 6'd2, 16'sh8000);
    send_item(mme_pkg::FUNC_LOAD_LEFT, 6'd3, 16'sh8000);
    send_item(mme_pkg::FUNC_LOAD_LEFT, 6'd63, 16'sh7fff);
    send_item(mme_pkg::FUNC_LOAD_RIGHT, 6'd63, 16'sh8000);
    send_item(mme_pkg::FUNC_COMPUTE, 6'd0, 16'sd0);
    drain();
  endtask

  // Random phases: new dimensions in most, well-formed operand loads, a little noise,
  // then a compute. Mostly small shapes.
  task automatic test_random_phases(int unsigned sp, int unsigned rp, int unsigned phases);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int unsigned ph = 0; ph < phases; ph++) begin
      if ($urandom_range(3) != 0) begin
        set_dims(($urandom_range(9) == 0) ? 4'd0 : 4'($urandom_range(1, 4)),
                 ($urandom_range(9) == 0) ? 4'd15 : 4'($urandom_range(1, 4)),
                 4'($urandom_range(1, 4)));
      end
      load_operands($urandom_range(2) == 0);
      repeat ($urandom_range(0, 2)) begin
        send_item(mme_pkg::func_e'($urandom_range(0, 3) == 3 ? mme_pkg::FUNC_NONE
                                                             : $urandom_range(0, 1)),
                  6'($urandom), rand_value());
      end
      load_operands(1'b0);   // noise may not leave a needed entry unwritten, but be safe
      send_item(mme_pkg::FUNC_COMPUTE, 6'($urandom), mme_pkg::VAL_W'($urandom));
    end
    drain();
  endtask

  // Hold the result channel off for a long stretch while a second compute is offered,
  // so the engine fills up and stalls its input; wait until all is out, then compute once more.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_dims(4'd3, 4'd3, 4'd2);
    load_operands(1'b1);
    hold_reqs++;
    send_item(mme_pkg::FUNC_COMPUTE, 6'd0, 16'sd0);
    send_item(mme_pkg::FUNC_COMPUTE, 6'd0, 16'sd0);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_products.size() != 0) @(posedge clk_i);
    send_item(mme_pkg::FUNC_COMPUTE, 6'd0, 16'sd0);
    drain();
  endtask

  // Largest rows and columns once: all 64 products in one run.
  task automatic test_max_shape();
    set_dims(4'd8, 4'd8, 4'd2);
    load_operands(1'b0);
    send_item(mme_pkg::FUNC_COMPUTE, 6'd0, 16'sd0);
    drain();
  endtask

  // Receiver: random stall, or a long hold-off counted here when one is requested.
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_CYC - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted product with the oldest expectation.
  always @(posedge clk_i) begin
    product_t exp_p;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_products++;
      if (pending_products.size() == 0) begin
        $error("unexpected product row %0d col %0d value %0d", row_idx_o, col_idx_o,
               result_o);
        n_errors++;
      end else begin
        exp_p = pending_products.pop_front();
        if (result_o !== exp_p.sum) begin
          $error("result: expected %0d, got %0d", exp_p.sum, result_o);
          n_errors++;
        end
        if (row_idx_o !== exp_p.row) begin
          $error("row_idx: expected %0d, got %0d", exp_p.row, row_idx_o);
          n_errors++;
        end
        if (col_idx_o !== exp_p.col) begin
          $error("col_idx: expected %0d, got %0d", exp_p.col, col_idx_o);
          n_errors++;
        end
        if (last_o !== exp_p.last) begin
          $error("last: expected %0b, got %0b", exp_p.last, last_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = mme_pkg::FUNC_NONE;
    index_i       = '0;
    value_i       = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = mme_pkg::REG_NONE;
    cfg_data_i    = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_items       = 0;
    n_computes    = 0;
    n_rows        = DIM_MAX;
    n_cols        = DIM_MAX;
    n_inner       = DIM_MAX;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      left_set[i]  = 1'b0;
      right_set[i] = 1'b0;
      left_mat[i]  = '0;
      right_mat[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_random_phases(22, 45, 4);
    test_random_phases(45, 22, 4);
    test_random_phases(0, 0, 3);
    test_directed_shapes();
    test_backpressure();
    test_max_shape();

    $display("Covered %0d input transactions, %0d computes, %0d products checked,",
             n_items, n_computes, n_products);
    $display("dimensions from 1 to 8 with clamping, stalls on both sides and a long hold-off.");
    if (n_errors == 0 && pending_products.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
